// ----- rtl/mse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the MIPS subset execute block.
// Used by the front decoder, the instruction queue, the back end, the top level and the checker.
package mse_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned RegAddrW = 5;
	localparam int unsigned ImmW     = 16;
	localparam int unsigned InTdataW = 32;

	// major opcodes
	localparam logic [5:0] OPC_SPECIAL  = 6'd0;
	localparam logic [5:0] OPC_BEQ      = 6'd4;
	localparam logic [5:0] OPC_BNE      = 6'd5;
	localparam logic [5:0] OPC_ADDI     = 6'd8;
	localparam logic [5:0] OPC_SLTI     = 6'd10;
	localparam logic [5:0] OPC_ANDI     = 6'd12;
	localparam logic [5:0] OPC_ORI      = 6'd13;
	localparam logic [5:0] OPC_XORI     = 6'd14;
	localparam logic [5:0] OPC_LUI      = 6'd15;
	localparam logic [5:0] OPC_SPECIAL2 = 6'd28;

	// function codes
	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_SLT     = 6'd42;
	localparam logic [5:0] FN_MUL     = 6'd2;

	// syscall service numbers in v0
	localparam logic [WordW-1:0] SYS_PRINT_INT  = 32'd1;
	localparam logic [WordW-1:0] SYS_EXIT       = 32'd10;
	localparam logic [WordW-1:0] SYS_PRINT_CHAR = 32'd11;

	localparam logic [RegAddrW-1:0] REG_V0 = 5'd2;
	localparam logic [RegAddrW-1:0] REG_A0 = 5'd4;

	typedef enum logic [2:0] {
		ACT_PLAIN      = 3'd0,
		ACT_BRANCH     = 3'd1,
		ACT_PRINT_INT  = 3'd2,
		ACT_PRINT_CHAR = 3'd3,
		ACT_EXIT       = 3'd4,
		ACT_UNKNOWN    = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_AND,
		OP_OR,
		OP_XOR,
		OP_SLT,
		OP_SLL,
		OP_SRL,
		OP_MUL,
		OP_LUI,
		OP_BEQ,
		OP_BNE,
		OP_SYSCALL,
		OP_UNKNOWN
	} exec_op_t;

	// classified instruction handed from the front to the back
	typedef struct packed {
		exec_op_t            op;
		logic                use_imm;
		logic [RegAddrW-1:0] rs;
		logic [RegAddrW-1:0] rt;
		logic [RegAddrW-1:0] dest;
		logic [RegAddrW-1:0] shamt;
		logic [ImmW-1:0]     imm16;
		logic [WordW-1:0]    imm32;
	} decoded_t;

	// result item, action in the lowest bits
	typedef struct packed {
		logic [WordW-1:0]    write_value;
		logic [RegAddrW-1:0] write_index;
		logic                write_enable;
		logic [WordW-1:0]    print_value;
		logic [ImmW-1:0]     branch_offset;
		action_t             action;
	} result_t;

	localparam int unsigned ResultW   = $bits(result_t);
	localparam int unsigned OutTdataW = ((ResultW + 7) / 8) * 8;

endpackage

// ----- rtl/mse_front.sv -----
`timescale 1ns / 1ps
// Front end: takes instruction transactions and classifies them into decoded_t.
// Depends on mse_pkg; feeds mse_queue.
module mse_front (
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mse_pkg::InTdataW-1:0]        s_axis_tdata,
	input  logic                                queue_full,
	output logic                                push,
	output mse_pkg::decoded_t                   push_data
);

	logic [5:0] opc;
	logic [5:0] fn;
	logic [mse_pkg::ImmW-1:0] imm;

	assign opc = s_axis_tdata[31:26];
	assign fn  = s_axis_tdata[5:0];
	assign imm = s_axis_tdata[15:0];

	assign s_axis_tready = !queue_full;
	assign push          = s_axis_tvalid && !queue_full;

	always_comb begin
		push_data         = '0;
		push_data.op      = mse_pkg::OP_UNKNOWN;
		push_data.use_imm = 1'b0;
		push_data.rs      = s_axis_tdata[25:21];
		push_data.rt      = s_axis_tdata[20:16];
		push_data.dest    = s_axis_tdata[15:11];
		push_data.shamt   = s_axis_tdata[10:6];
		push_data.imm16   = imm;
		push_data.imm32   = '0;
		case (opc)
			mse_pkg::OPC_SPECIAL: begin
				case (fn)
					mse_pkg::FN_ADD:     push_data.op = mse_pkg::OP_ADD;
					mse_pkg::FN_SUB:     push_data.op = mse_pkg::OP_SUB;
					mse_pkg::FN_AND:     push_data.op = mse_pkg::OP_AND;
					mse_pkg::FN_OR:      push_data.op = mse_pkg::OP_OR;
					mse_pkg::FN_SLT:     push_data.op = mse_pkg::OP_SLT;
					mse_pkg::FN_SLL:     push_data.op = mse_pkg::OP_SLL;
					mse_pkg::FN_SRL:     push_data.op = mse_pkg::OP_SRL;
					mse_pkg::FN_SYSCALL: push_data.op = mse_pkg::OP_SYSCALL;
					default:             push_data.op = mse_pkg::OP_UNKNOWN;
				endcase
			end
			mse_pkg::OPC_SPECIAL2: begin
				if (fn == mse_pkg::FN_MUL) begin
					push_data.op = mse_pkg::OP_MUL;
				end
			end
			mse_pkg::OPC_BEQ: push_data.op = mse_pkg::OP_BEQ;
			mse_pkg::OPC_BNE: push_data.op = mse_pkg::OP_BNE;
			mse_pkg::OPC_ADDI: begin
				push_data.op      = mse_pkg::OP_ADD;
				push_data.use_imm = 1'b1;
				push_data.dest    = s_axis_tdata[20:16];
				push_data.imm32   = {{16{imm[15]}}, imm};
			end
			mse_pkg::OPC_SLTI: begin
				push_data.op      = mse_pkg::OP_SLT;
				push_data.use_imm = 1'b1;
				push_data.dest    = s_axis_tdata[20:16];
				push_data.imm32   = {{16{imm[15]}}, imm};
			end
			mse_pkg::OPC_ANDI: begin
				push_data.op      = mse_pkg::OP_AND;
				push_data.use_imm = 1'b1;
				push_data.dest    = s_axis_tdata[20:16];
				push_data.imm32   = {16'd0, imm};
			end
			mse_pkg::OPC_ORI: begin
				push_data.op      = mse_pkg::OP_OR;
				push_data.use_imm = 1'b1;
				push_data.dest    = s_axis_tdata[20:16];
				push_data.imm32   = {16'd0, imm};
			end
			mse_pkg::OPC_XORI: begin
				push_data.op      = mse_pkg::OP_XOR;
				push_data.use_imm = 1'b1;
				push_data.dest    = s_axis_tdata[20:16];
				push_data.imm32   = {16'd0, imm};
			end
			mse_pkg::OPC_LUI: begin
				push_data.op      = mse_pkg::OP_LUI;
				push_data.use_imm = 1'b1;
				push_data.dest    = s_axis_tdata[20:16];
				push_data.imm32   = {imm, 16'd0};
			end
			default: push_data.op = mse_pkg::OP_UNKNOWN;
		endcase
	end

endmodule

// ----- rtl/mse_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of decoded instructions between the front and the back end.
// Depends on mse_pkg for decoded_t.
module mse_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mse_pkg::decoded_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output mse_pkg::decoded_t head_data
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	mse_pkg::decoded_t entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		logic [PtrW-1:0] r;
		r = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- rtl/mse_back.sv -----
`timescale 1ns / 1ps
// Back end: operand fetch from the register file, execute, write back and result register.
// Depends on mse_pkg; pops instructions from mse_queue.
module mse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  mse_pkg::decoded_t head_data,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output mse_pkg::result_t  res_data
);

	localparam int unsigned RegCount = 2 ** mse_pkg::RegAddrW;

	// register file; an entry never written reads as zero
	logic [mse_pkg::WordW-1:0] regfile_q [RegCount];
	logic [RegCount-1:0]       reg_valid_q;
	logic [mse_pkg::WordW-1:0] v0_q;
	logic [mse_pkg::WordW-1:0] a0_q;
	logic                      halted_q;

	// execute stage
	logic                      valid_s2;
	mse_pkg::decoded_t         dec_s2;
	logic [mse_pkg::WordW-1:0] a_s2;
	logic [mse_pkg::WordW-1:0] b_s2;

	logic                      out_valid_q;
	mse_pkg::result_t          out_res_q;

	logic                      fire;
	logic                      load_s2;
	logic [mse_pkg::WordW-1:0] opb;
	logic [mse_pkg::WordW-1:0] mul_lo;
	logic                      wr_en;
	logic [mse_pkg::WordW-1:0] wr_val;
	logic                      set_halt;
	mse_pkg::result_t          res;
	logic                      fwd_a;
	logic                      fwd_b;

	assign fire    = valid_s2 && (!out_valid_q || res_ready);
	assign load_s2 = head_valid && (!valid_s2 || fire);
	assign pop     = load_s2;

	assign opb    = dec_s2.use_imm ? dec_s2.imm32 : b_s2;
	assign mul_lo = a_s2 * b_s2;

	always_comb begin
		wr_en    = 1'b0;
		wr_val   = '0;
		set_halt = 1'b0;
		res      = '0;
		res.action = mse_pkg::ACT_PLAIN;
		if (halted_q) begin
			res.action = mse_pkg::ACT_EXIT;
		end else begin
			case (dec_s2.op)
				mse_pkg::OP_ADD: begin
					wr_en  = 1'b1;
					wr_val = a_s2 + opb;
				end
				mse_pkg::OP_SUB: begin
					wr_en  = 1'b1;
					wr_val = a_s2 - opb;
				end
				mse_pkg::OP_AND: begin
					wr_en  = 1'b1;
					wr_val = a_s2 & opb;
				end
				mse_pkg::OP_OR: begin
					wr_en  = 1'b1;
					wr_val = a_s2 | opb;
				end
				mse_pkg::OP_XOR: begin
					wr_en  = 1'b1;
					wr_val = a_s2 ^ opb;
				end
				mse_pkg::OP_SLT: begin
					wr_en  = 1'b1;
					wr_val = {31'd0, ($signed(a_s2) < $signed(opb))};
				end
				mse_pkg::OP_SLL: begin
					wr_en  = 1'b1;
					wr_val = b_s2 << dec_s2.shamt;
				end
				mse_pkg::OP_SRL: begin
					wr_en  = 1'b1;
					wr_val = b_s2 >> dec_s2.shamt;
				end
				mse_pkg::OP_MUL: begin
					wr_en  = 1'b1;
					wr_val = mul_lo;
				end
				mse_pkg::OP_LUI: begin
					wr_en  = 1'b1;
					wr_val = dec_s2.imm32;
				end
				mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
					if ((dec_s2.op == mse_pkg::OP_BEQ) == (a_s2 == b_s2)) begin
						res.action        = mse_pkg::ACT_BRANCH;
						res.branch_offset = dec_s2.imm16;
					end
				end
				mse_pkg::OP_SYSCALL: begin
					if (v0_q == mse_pkg::SYS_PRINT_INT) begin
						res.action      = mse_pkg::ACT_PRINT_INT;
						res.print_value = a0_q;
					end else if (v0_q == mse_pkg::SYS_PRINT_CHAR) begin
						res.action      = mse_pkg::ACT_PRINT_CHAR;
						res.print_value = {24'd0, a0_q[7:0]};
					end else if (v0_q == mse_pkg::SYS_EXIT) begin
						res.action = mse_pkg::ACT_EXIT;
						set_halt   = 1'b1;
					end
				end
				default: res.action = mse_pkg::ACT_UNKNOWN;
			endcase
			// drop writes to register zero
			if (dec_s2.dest == '0) begin
				wr_en = 1'b0;
			end
		end
		if (wr_en) begin
			res.write_enable = 1'b1;
			res.write_index  = dec_s2.dest;
			res.write_value  = wr_val;
		end
	end

	// forward the write retiring this cycle into the operands being fetched
	assign fwd_a = fire && wr_en && (dec_s2.dest == head_data.rs);
	assign fwd_b = fire && wr_en && (dec_s2.dest == head_data.rt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_valid_q <= '0;
			v0_q        <= '0;
			a0_q        <= '0;
			halted_q    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (fire) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && wr_en) begin
				reg_valid_q[dec_s2.dest] <= 1'b1;
				if (dec_s2.dest == mse_pkg::REG_V0) begin
					v0_q <= wr_val;
				end
				if (dec_s2.dest == mse_pkg::REG_A0) begin
					a0_q <= wr_val;
				end
			end
			if (fire && set_halt) begin
				halted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			regfile_q[dec_s2.dest] <= wr_val;
		end
		if (load_s2) begin
			dec_s2 <= head_data;
			if (fwd_a) begin
				a_s2 <= wr_val;
			end else begin
				a_s2 <= reg_valid_q[head_data.rs] ? regfile_q[head_data.rs] : '0;
			end
			if (fwd_b) begin
				b_s2 <= wr_val;
			end else begin
				b_s2 <= reg_valid_q[head_data.rt] ? regfile_q[head_data.rt] : '0;
			end
		end
		if (fire) begin
			out_res_q <= res;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_res_q;

endmodule

// ----- rtl/mips_subset_instruction_execute.sv -----
`timescale 1ns / 1ps
// Top level of the MIPS subset execute block: front decoder, instruction queue, back end.
// Depends on mse_pkg, mse_front, mse_queue and mse_back.
//
// Usage:
//   s_axis carries one 32-bit instruction word per transaction. m_axis returns exactly
//   one result transaction per instruction, in order: action, branch offset, print
//   value and the register write-back (index and value).
//   Throughput is one instruction per cycle while m_axis_tready is high. The back end
//   executes an instruction held in the execute-stage register, loaded as it leaves the
//   queue; operands come from the register file read registered at the queue pop, with
//   the write retiring in that same cycle forwarded. On its way to m_axis_tvalid an
//   instruction passes the queue entry, the execute-stage register and the result register.
//   When m_axis_tready is low the result register holds, the execute stage holds
//   behind it, and the queue keeps taking instructions until it holds QUEUE_DEPTH
//   entries; then s_axis_tready drops.
//   Reset clears the register file to zero (per-entry valid bits), clears the halted
//   flag and empties the pipeline; no clearing pass is needed. After an exit syscall
//   every further instruction reports exit and changes nothing.
module mips_subset_instruction_execute #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] instruction_word
	input  logic [mse_pkg::InTdataW-1:0]      s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [2:0] action, [18:3] branch_offset, [50:19] print_value, [51] write_enable,
	// [56:52] write_index, [88:57] write_value, upper bits zero
	output logic [mse_pkg::OutTdataW-1:0]     m_axis_tdata
);

	logic              queue_full;
	logic              push;
	mse_pkg::decoded_t push_data;
	logic              pop;
	logic              head_valid;
	mse_pkg::decoded_t head_data;
	mse_pkg::result_t  res_data;

	mse_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.queue_full    (queue_full),
		.push          (push),
		.push_data     (push_data)
	);

	mse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	mse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_data   (res_data)
	);

	assign m_axis_tdata = {{(mse_pkg::OutTdataW - mse_pkg::ResultW){1'b0}}, res_data};

endmodule

// ----- rtl/mse_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the MIPS subset execute block, bound to the top level.
// Depends on mse_pkg for the result layout.
module mse_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mse_pkg::OutTdataW-1:0] m_axis_tdata
);

	mse_pkg::result_t res;

	assign res = mse_pkg::result_t'(m_axis_tdata[mse_pkg::ResultW-1:0]);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_wr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.write_enable |-> res.write_index == '0 && res.write_value == '0)
		else $error("write fields set without write enable");

	a_wr_plain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.write_enable |->
			res.action == mse_pkg::ACT_PLAIN && res.write_index != '0)
		else $error("write-back with non-plain action or to register zero");

	a_branch: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.action != mse_pkg::ACT_BRANCH |-> res.branch_offset == '0)
		else $error("branch offset without taken branch");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.action == mse_pkg::ACT_PRINT_CHAR |-> res.print_value[31:8] == '0)
		else $error("print character value wider than a byte");

endmodule

bind mips_subset_instruction_execute mse_checker u_mse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
